>>> rtl/core/multilevel_interrupt_aggregator_assert.svh
// assertion macros, clocked on clk and disabled while rst_n is low
`ifndef MULTILEVEL_INTERRUPT_AGGREGATOR_ASSERT_SVH
`define MULTILEVEL_INTERRUPT_AGGREGATOR_ASSERT_SVH

// same-cycle implication
`define MIA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mia assertion failed");

// next-cycle implication
`define MIA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mia assertion failed");

`endif

>>> rtl/core/mia_pkg.sv
package mia_pkg;

  localparam int SOURCES_DEF = 32;
  localparam int LEVELS_DEF  = 8;

  localparam int CMD_W      = 3;
  localparam int LEVEL_W    = 4;
  localparam int MASK_W     = 32;
  localparam int GRANT_W    = 32;
  localparam int PEND_W     = 8;
  localparam int LIM_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int ACTIVE_W   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_EDGE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 1'b1;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 4'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 3'd0,
    CMD_RELEASE = 3'd1,
    CMD_REQUEST = 3'd2,
    CMD_ACK     = 3'd3,
    CMD_CLEAR   = 3'd4
  } mia_cmd_t;

  typedef struct packed {
    logic wr_en;
    logic err;
    logic pend_we;
    logic pend_val;
    logic clr_all;
  } mia_ctrl_t;

endpackage

>>> rtl/core/mia_ram.sv
module mia_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/mia_exec.sv
module mia_exec import mia_pkg::*; #(
  parameter int SOURCES = SOURCES_DEF
) (
  input  logic [CMD_W-1:0]   cmd,
  input  logic [LEVEL_W-1:0] level,
  input  logic [LIM_W-1:0]   lim,
  input  logic               edge_mode,
  input  logic               assert_req,
  input  logic [SOURCES-1:0] mask,
  input  logic [SOURCES-1:0] use_old,
  input  logic [SOURCES-1:0] req_old,
  output logic [SOURCES-1:0] use_new,
  output logic [SOURCES-1:0] req_new,
  output logic [SOURCES-1:0] grant,
  output mia_ctrl_t          ctrl
);

  logic               in_range;
  logic [SOURCES-1:0] req_drive;
  logic               drive_set;

  assign in_range  = (level != '0) && ({1'b0, level} <= lim);
  assign drive_set = (cmd == CMD_REQUEST) && assert_req;
  assign req_drive = drive_set ? (req_old | mask) : (req_old & ~mask);

  always_comb begin
    use_new = use_old;
    req_new = req_old;
    grant   = '0;
    ctrl    = '0;
    case (cmd)
      CMD_ALLOC: begin
        if (in_range) begin
          // lowest clear bit; zero when all are taken
          grant      = ~use_old & (use_old + SOURCES'(1));
          use_new    = use_old | grant;
          ctrl.wr_en = 1'b1;
        end else begin
          ctrl.err = 1'b1;
        end
      end
      CMD_RELEASE, CMD_REQUEST: begin
        if (in_range) begin
          req_new    = req_drive;
          ctrl.wr_en = 1'b1;
          if (cmd == CMD_RELEASE) begin
            use_new  = use_old & ~mask;
            ctrl.err = ((use_old & mask) == '0);
          end
          if (edge_mode) begin
            // latch only on a zero to nonzero change of the request mask
            ctrl.pend_we  = (req_old == '0) && (req_drive != '0);
            ctrl.pend_val = 1'b1;
          end else begin
            ctrl.pend_we  = 1'b1;
            ctrl.pend_val = (req_drive != '0);
          end
        end else begin
          ctrl.err = 1'b1;
        end
      end
      CMD_ACK: begin
        if (in_range) begin
          if (edge_mode) begin
            req_new       = '0;
            ctrl.wr_en    = 1'b1;
            ctrl.pend_we  = 1'b1;
            ctrl.pend_val = 1'b0;
          end
        end else begin
          ctrl.err = 1'b1;
        end
      end
      CMD_CLEAR: begin
        ctrl.clr_all = 1'b1;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

endmodule

>>> rtl/core/multilevel_interrupt_aggregator.sv
// pipeline: a command is registered into the execute stage together with its ram read, and its
//   result is registered into the output register once that register is free or being taken
// throughput: one command per cycle unless out_ready stalls the output; each reads its level's
//   masks from the ram, modifies and rewrites them; back-to-back hits on one level use a bypass
// reset: synchronous active-low rst_n clears pipeline valids, pending flags and the per-level
//   valid bits that make unwritten ram entries read as zero; no clearing pass is needed
module multilevel_interrupt_aggregator import mia_pkg::*; #(
  parameter int SOURCES = SOURCES_DEF,
  parameter int LEVELS  = LEVELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [LEVEL_W-1:0]    in_level,
  input  logic [MASK_W-1:0]     in_source_mask,
  input  logic                  in_assert_request,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [GRANT_W-1:0]    out_granted_mask,
  output logic [PEND_W-1:0]     out_pending_levels,
  output logic                  out_error
);

  `include "multilevel_interrupt_aggregator_assert.svh"

  localparam int AW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int DW = 2 * SOURCES;

  // configuration
  logic                edge_r;
  logic [ACTIVE_W-1:0] active_r;
  logic [LIM_W-1:0]    lim;

  // execute stage
  logic               s_vld_r;
  logic [CMD_W-1:0]   s_cmd_r;
  logic [LEVEL_W-1:0] s_level_r;
  logic [AW-1:0]      s_addr_r;
  logic [SOURCES-1:0] s_mask_r;
  logic               s_assert_r;
  logic               s_done;
  logic               accept;

  // bypass of the write made in the cycle of the read
  logic               fwd_vld_r;
  logic [AW-1:0]      fwd_addr_r;
  logic [DW-1:0]      fwd_data_r;
  logic               fwd_hit;

  logic [LEVELS-1:0]  use_vld_r;
  logic [LEVELS-1:0]  req_vld_r;
  logic [LEVELS-1:0]  pend_r;
  logic [LEVELS-1:0]  pend_nxt;

  logic [DW-1:0]      rd_data;
  logic [DW-1:0]      entry;
  logic [SOURCES-1:0] use_old;
  logic [SOURCES-1:0] req_old;
  logic [SOURCES-1:0] use_new;
  logic [SOURCES-1:0] req_new;
  logic [SOURCES-1:0] grant;
  mia_ctrl_t          ctrl;
  logic               wr_en;

  logic [63:0]        in_mask_ext;
  logic [63:0]        grant_ext;
  logic [AW-1:0]      in_addr;
  logic [LEVEL_W-1:0] in_level_m1;
  logic [PEND_W-1:0]  pend_map;

  logic               out_valid_r;
  logic [GRANT_W-1:0] out_grant_r;
  logic [PEND_W-1:0]  out_pend_r;
  logic               out_err_r;

  assign lim = (active_r > LEVELS) ? LIM_W'(LEVELS) : {1'b0, active_r};

  assign s_done   = s_vld_r && (!out_valid_r || out_ready);
  assign in_ready = !s_vld_r || s_done;
  assign accept   = in_valid && in_ready;

  assign in_level_m1 = in_level - LEVEL_W'(1);
  assign in_addr     = in_level_m1[AW-1:0];
  assign in_mask_ext = {32'b0, in_source_mask};

  mia_ram #(
    .WIDTH (DW),
    .DEPTH (LEVELS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s_addr_r),
    .wdata ({use_new, req_new}),
    .re    (accept),
    .raddr (in_addr),
    .rdata (rd_data)
  );

  assign fwd_hit = fwd_vld_r && (fwd_addr_r == s_addr_r);
  assign entry   = fwd_hit ? fwd_data_r : rd_data;
  assign use_old = (fwd_hit || use_vld_r[s_addr_r]) ? entry[DW-1:SOURCES] : '0;
  assign req_old = (fwd_hit || req_vld_r[s_addr_r]) ? entry[SOURCES-1:0] : '0;

  mia_exec #(
    .SOURCES (SOURCES)
  ) u_exec (
    .cmd        (s_cmd_r),
    .level      (s_level_r),
    .lim        (lim),
    .edge_mode  (edge_r),
    .assert_req (s_assert_r),
    .mask       (s_mask_r),
    .use_old    (use_old),
    .req_old    (req_old),
    .use_new    (use_new),
    .req_new    (req_new),
    .grant      (grant),
    .ctrl       (ctrl)
  );

  assign wr_en = s_done && ctrl.wr_en;

  always_comb begin
    pend_nxt = pend_r;
    if (s_done) begin
      if (ctrl.clr_all) begin
        pend_nxt = '0;
      end else if (ctrl.pend_we) begin
        pend_nxt[s_addr_r] = ctrl.pend_val;
      end
    end
  end

  always_comb begin
    pend_map = '0;
    for (int i = 0; i < PEND_W; i++) begin
      if ((i < LEVELS) && (i < int'(lim))) begin
        pend_map[i] = pend_nxt[i % LEVELS];
      end
    end
  end

  assign grant_ext = 64'(grant);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_r      <= 1'b0;
      active_r    <= ACTIVE_RST;
      s_vld_r     <= 1'b0;
      fwd_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      use_vld_r   <= '0;
      req_vld_r   <= '0;
      pend_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_EDGE:   edge_r   <= cfg_wdata[0];
          REG_ACTIVE: active_r <= cfg_wdata[ACTIVE_W-1:0];
          default:    edge_r   <= edge_r;
        endcase
      end
      if (accept) begin
        s_vld_r   <= 1'b1;
        fwd_vld_r <= wr_en;
      end else if (s_done) begin
        s_vld_r <= 1'b0;
      end
      if (s_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        use_vld_r[s_addr_r] <= 1'b1;
        req_vld_r[s_addr_r] <= 1'b1;
      end else if (s_done && ctrl.clr_all) begin
        req_vld_r <= '0;
      end
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_cmd_r    <= in_cmd;
      s_level_r  <= in_level;
      s_addr_r   <= in_addr;
      s_mask_r   <= in_mask_ext[SOURCES-1:0];
      s_assert_r <= in_assert_request;
      fwd_addr_r <= s_addr_r;
      fwd_data_r <= {use_new, req_new};
    end
    if (s_done) begin
      out_grant_r <= grant_ext[GRANT_W-1:0];
      out_pend_r  <= pend_map;
      out_err_r   <= ctrl.err;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_granted_mask   = out_grant_r;
  assign out_pending_levels = out_pend_r;
  assign out_error          = out_err_r;

  `MIA_ASSERT_NEXT(a_clear_wipes, s_done && (s_cmd_r == CMD_CLEAR), pend_r == '0)
  `MIA_ASSERT_IMP(a_grant_onehot, out_valid_r, $onehot0(out_grant_r))
  `MIA_ASSERT_IMP(a_err_no_grant, out_valid_r && out_err_r, out_grant_r == '0)
  `MIA_ASSERT_NEXT(a_stall_holds, s_vld_r && !s_done, s_vld_r && $stable(s_cmd_r))
  `MIA_ASSERT_IMP(a_write_clear_excl, s_done, !(ctrl.wr_en && ctrl.clr_all))

endmodule
